### design/kes_pkg.sv
// ----------------------------------------------------------------------------
// kes_pkg
// Shared types and constants of the Kruskal edge selector.
// ----------------------------------------------------------------------------
package kes_pkg;

  localparam int NODE_W     = 6;
  localparam int WEIGHT_W   = 32;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_MODE   = 1'b1;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [CNT_W-1:0] NODE_COUNT_MIN = 7'd2;

  typedef struct packed {
    logic                first_edge;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                accepted;
    logic [NODE_W-1:0]   edge_a;
    logic [NODE_W-1:0]   edge_b;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                tree_done;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] node_count;
    logic             tie_group_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_WALK,
    ST_FIN
  } state_e;

endpackage

### design/kes_edge_if.sv
// ----------------------------------------------------------------------------
// kes_edge_if
// Valid/ready channel carrying one edge item.
// ----------------------------------------------------------------------------
interface kes_edge_if import kes_pkg::*; ();
  logic  valid;
  logic  ready;
  edge_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/kes_result_if.sv
// ----------------------------------------------------------------------------
// kes_result_if
// Valid/ready channel carrying one edge verdict.
// ----------------------------------------------------------------------------
interface kes_result_if import kes_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/kes_ram.sv
// ----------------------------------------------------------------------------
// kes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kes_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/kes_ctrl.sv
// ----------------------------------------------------------------------------
// kes_ctrl
// Sequencer: label reads, compare, relabel walk, group copy and clear sweep.
// ----------------------------------------------------------------------------
module kes_ctrl import kes_pkg::*; #(
  parameter int NODES = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  kes_edge_if.sink                 edge_i,
  kes_result_if.source             result_o,
  output logic [$clog2(NODES)-1:0] mem_raddr_o,
  output logic [$clog2(NODES)-1:0] mem_waddr_o,
  output logic                     live_we_o,
  output logic [$clog2(NODES)-1:0] live_wdata_o,
  input  logic [$clog2(NODES)-1:0] live_rdata_i,
  output logic                     pend_we_o,
  output logic [$clog2(NODES)-1:0] pend_wdata_o,
  input  logic [$clog2(NODES)-1:0] pend_rdata_i
);

  localparam int AW = $clog2(NODES);
  localparam int CW = AW + 1;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  edge_t            item_q, item_d;
  logic [WEIGHT_W-1:0] gw_q, gw_d;
  logic [CNT_W-1:0] acc_cnt_q, acc_cnt_d;
  logic             acc_q, acc_d;
  logic             done_q, done_d;
  logic             join_live_q, join_live_d;
  logic [AW-1:0]    la_q, la_d, pa_q, pa_d;
  logic [AW-1:0]    from_l_q, from_l_d, to_l_q, to_l_d;
  logic [AW-1:0]    from_p_q, from_p_d, to_p_q, to_p_d;
  result_t          out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] limit;
  logic             in_range;
  logic             differ;
  logic [CNT_W-1:0] acc_cnt_inc;

  // effective node count, clamped between NODE_COUNT_MIN and the storage depth
  always_comb begin
    if (cfg_i.node_count < NODE_COUNT_MIN) begin
      n_eff = NODE_COUNT_MIN;
    end else if (32'(cfg_i.node_count) > NODES) begin
      n_eff = CNT_W'(NODES);
    end else begin
      n_eff = cfg_i.node_count;
    end
  end

  assign limit       = n_eff - CNT_W'(1);
  assign in_range    = (CNT_W'(item_q.node_a) < n_eff) && (CNT_W'(item_q.node_b) < n_eff);
  assign differ      = (la_q != live_rdata_i);
  assign acc_cnt_inc = acc_cnt_q + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    item_d       = item_q;
    gw_d         = gw_q;
    acc_cnt_d    = acc_cnt_q;
    acc_d        = acc_q;
    done_d       = done_q;
    join_live_d  = join_live_q;
    la_d         = la_q;
    pa_d         = pa_q;
    from_l_d     = from_l_q;
    to_l_d       = to_l_q;
    from_p_d     = from_p_q;
    to_p_d       = to_p_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q && !result_o.ready;
    mem_raddr_o  = '0;
    mem_waddr_o  = rd_idx_q;
    live_we_o    = 1'b0;
    live_wdata_o = pend_rdata_i;
    pend_we_o    = 1'b0;
    pend_wdata_o = to_p_q;
    edge_i.ready = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        live_we_o    = 1'b1;
        pend_we_o    = 1'b1;
        mem_waddr_o  = cnt_q[AW-1:0];
        live_wdata_o = cnt_q[AW-1:0];
        pend_wdata_o = cnt_q[AW-1:0];
        cnt_d        = cnt_q + CW'(1);
        if (32'(cnt_q) == NODES - 1) begin
          cnt_d   = '0;
          state_d = item_q.first_edge ? ST_RD_A : ST_IDLE;
        end
      end
      ST_IDLE: begin
        edge_i.ready = 1'b1;
        if (edge_i.valid) begin
          item_d = edge_i.data;
          gw_d   = edge_i.data.weight;
          cnt_d  = '0;
          if (edge_i.data.first_edge) begin
            acc_cnt_d = '0;
            state_d   = ST_CLEAR;
          end else if (cfg_i.tie_group_mode && (edge_i.data.weight != gw_q)) begin
            state_d = ST_COPY;
          end else begin
            state_d = ST_RD_A;
          end
        end
      end
      ST_COPY: begin
        // pending table into live table, one entry a cycle
        live_we_o    = rd_vld_q;
        live_wdata_o = pend_rdata_i;
        if (32'(cnt_q) < NODES) begin
          mem_raddr_o = cnt_q[AW-1:0];
          rd_vld_d    = 1'b1;
          rd_idx_d    = cnt_q[AW-1:0];
          cnt_d       = cnt_q + CW'(1);
        end else begin
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: begin
        mem_raddr_o = AW'(item_q.node_a);
        state_d     = ST_RD_B;
      end
      ST_RD_B: begin
        mem_raddr_o = AW'(item_q.node_b);
        la_d        = live_rdata_i;
        pa_d        = pend_rdata_i;
        state_d     = ST_CMP;
      end
      ST_CMP: begin
        from_l_d = live_rdata_i;
        to_l_d   = la_q;
        from_p_d = pend_rdata_i;
        to_p_d   = pa_q;
        cnt_d    = '0;
        if (cfg_i.tie_group_mode) begin
          acc_d       = in_range && differ;
          join_live_d = 1'b0;
          done_d      = 1'b0;
        end else begin
          acc_d       = in_range && (acc_cnt_q < limit) && differ;
          join_live_d = acc_d;
          if (acc_d) begin
            acc_cnt_d = acc_cnt_inc;
          end
          done_d = acc_d ? (acc_cnt_inc >= limit) : (acc_cnt_q >= limit);
        end
        state_d = acc_d ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        // relabel entries that carry the label of node b
        live_we_o    = rd_vld_q && join_live_q && (live_rdata_i == from_l_q);
        live_wdata_o = to_l_q;
        pend_we_o    = rd_vld_q && (pend_rdata_i == from_p_q);
        pend_wdata_o = to_p_q;
        if (32'(cnt_q) < 32'(n_eff)) begin
          mem_raddr_o = cnt_q[AW-1:0];
          rd_vld_d    = 1'b1;
          rd_idx_d    = cnt_q[AW-1:0];
          cnt_d       = cnt_q + CW'(1);
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_vld_q || result_o.ready) begin
          out_d.accepted    = acc_q;
          out_d.edge_a      = item_q.node_a;
          out_d.edge_b      = item_q.node_b;
          out_d.edge_weight = item_q.weight;
          out_d.tree_done   = done_q;
          out_vld_d         = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      gw_q        <= '0;
      acc_cnt_q   <= '0;
      out_vld_q   <= 1'b0;
      item_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      gw_q        <= gw_d;
      acc_cnt_q   <= acc_cnt_d;
      out_vld_q   <= out_vld_d;
      item_q      <= item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    acc_q       <= acc_d;
    done_q      <= done_d;
    join_live_q <= join_live_d;
    la_q        <= la_d;
    pa_q        <= pa_d;
    from_l_q    <= from_l_d;
    to_l_q      <= to_l_d;
    from_p_q    <= from_p_d;
    to_p_q      <= to_p_d;
    out_q       <= out_d;
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_i.valid && edge_i.ready) |=> !edge_i.ready)
    else $error("input taken while an edge is in flight");

  a_tie_walk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && cfg_i.tie_group_mode) |-> !live_we_o)
    else $error("live table written by a deferred join");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && rd_vld_q) |-> (32'(rd_idx_q) < 32'(n_eff)))
    else $error("relabel walk beyond node count");

  a_tie_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && cfg_i.tie_group_mode) |-> !result_o.data.tree_done)
    else $error("tree done flagged in tie-group mode");

endmodule

### design/kruskal_edge_selector_top.sv
// ----------------------------------------------------------------------------
// kruskal_edge_selector_top
// Kruskal edge selector on sorted edges, quick-find labels in two RAMs.
//
//   channel   dir  handshake      payload
//   edge_i    in   valid/ready    first_edge, node_a, node_b, weight
//   result_o  out  valid/ready    accepted, edge_a, edge_b, edge_weight, tree_done
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// an edge runs two label reads, a compare and a finish step, plus a join walk
// over n entries (n = effective node count), a group copy of all NODES entries
// and a first-edge clear, in sequence on the single read port of each label RAM
// after reset a clear sweep over all NODES entries runs with edge_i.ready low
// a waiting result does not block the next edge until its verdict is ready
// ----------------------------------------------------------------------------
module kruskal_edge_selector_top import kes_pkg::*; #(
  parameter int NODES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  kes_edge_if.sink              edge_i,
  kes_result_if.source          result_o
);

  localparam int AW = $clog2(NODES);

  cfg_t          cfg_q;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic          live_we;
  logic [AW-1:0] live_wdata;
  logic [AW-1:0] live_rdata;
  logic          pend_we;
  logic [AW-1:0] pend_wdata;
  logic [AW-1:0] pend_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_count     <= NODE_COUNT_RST;
      cfg_q.tie_group_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NODE_COUNT: cfg_q.node_count     <= cfg_wdata_i;
        CFG_TIE_MODE:   cfg_q.tie_group_mode <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  kes_ctrl #(
    .NODES (NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .edge_i       (edge_i),
    .result_o     (result_o),
    .mem_raddr_o  (mem_raddr),
    .mem_waddr_o  (mem_waddr),
    .live_we_o    (live_we),
    .live_wdata_o (live_wdata),
    .live_rdata_i (live_rdata),
    .pend_we_o    (pend_we),
    .pend_wdata_o (pend_wdata),
    .pend_rdata_i (pend_rdata)
  );

  kes_ram #(
    .WIDTH (AW),
    .DEPTH (NODES)
  ) u_live_ram (
    .clk_i   (clk_i),
    .we_i    (live_we),
    .waddr_i (mem_waddr),
    .wdata_i (live_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (live_rdata)
  );

  kes_ram #(
    .WIDTH (AW),
    .DEPTH (NODES)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (mem_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (pend_rdata)
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Kruskal edge selector: a table of directed edges and register
// writes, then phases of random graphs under varied node counts and both
// selection modes. Verdicts are compared with typed values or a behavioral model
// of the label tables kept here, with random input gaps and result backpressure.
// ----------------------------------------------------------------------------
module testbench import kes_pkg::*; ();

  localparam int NODE_CNT    = 64;
  localparam int HALF_PERIOD = 4;
  localparam int SETTLE_CYC  = 2 * NODE_CNT + 16;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int LIMIT_NS    = 8_000_000;

  typedef enum logic [1:0] {
    ROW_EDGE,
    ROW_CHECKED,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    edge_t                 e;
    logic                  acc;
    logic                  done;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  kes_edge_if   edge_if ();
  kes_result_if result_if ();

  kruskal_edge_selector_top #(.NODES(NODE_CNT)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_if),
    .result_o    (result_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // label tables and registers as the block should hold them
  logic [NODE_W-1:0]   live_label [NODE_CNT];
  logic [NODE_W-1:0]   pend_label [NODE_CNT];
  logic [WEIGHT_W-1:0] group_wt;
  int                  join_count;
  logic [CNT_W-1:0]    cfg_nodes;
  logic                cfg_tie;

  result_t verdict_q [$];
  int      fault_count = 0;
  bit      calm_tail   = 1'b0;
  int      stall_left  = 0;

  function automatic void clear_labels();
    for (int k = 0; k < NODE_CNT; k++) begin
      live_label[k] = k[NODE_W-1:0];
      pend_label[k] = k[NODE_W-1:0];
    end
  endfunction

  function automatic result_t judge_edge(edge_t e);
    int                n;
    logic              keep;
    logic [NODE_W-1:0] from_l, to_l, from_p, to_p;
    result_t           r;
    n = (cfg_nodes < NODE_COUNT_MIN) ? NODE_COUNT_MIN :
        ((cfg_nodes > NODE_CNT) ? NODE_CNT : cfg_nodes);
    if (e.first_edge) begin
      clear_labels();
      join_count = 0;
    end else if (cfg_tie && e.weight != group_wt) begin
      for (int k = 0; k < NODE_CNT; k++) live_label[k] = pend_label[k];
    end
    group_wt = e.weight;
    keep = 1'b0;
    if (e.node_a < n && e.node_b < n && live_label[e.node_a] != live_label[e.node_b] &&
        (cfg_tie || join_count < n - 1)) begin
      keep = 1'b1;
      from_l = live_label[e.node_b];
      to_l   = live_label[e.node_a];
      from_p = pend_label[e.node_b];
      to_p   = pend_label[e.node_a];
      for (int k = 0; k < n; k++) begin
        if (!cfg_tie && live_label[k] == from_l) live_label[k] = to_l;
        if (pend_label[k] == from_p) pend_label[k] = to_p;
      end
      if (!cfg_tie) join_count++;
    end
    r.accepted    = keep;
    r.edge_a      = e.node_a;
    r.edge_b      = e.node_b;
    r.edge_weight = e.weight;
    r.tree_done   = !cfg_tie && (join_count >= n - 1);
    return r;
  endfunction

  function automatic plan_row_t edge_row(row_kind_e kind, logic f, logic [NODE_W-1:0] a,
                                         logic [NODE_W-1:0] b, logic [WEIGHT_W-1:0] w,
                                         logic acc, logic done);
    plan_row_t row;
    row        = '0;
    row.kind   = kind;
    row.e      = '{first_edge: f, node_a: a, node_b: b, weight: w};
    row.acc    = acc;
    row.done   = done;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row         = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic send_edge(edge_t e, bit typed, result_t typed_verdict);
    int      gap;
    result_t predicted;
    gap = (!calm_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      edge_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    edge_if.valid <= 1'b1;
    edge_if.data  <= e;
    do @(posedge clk_i); while (!edge_if.ready);
    predicted = judge_edge(e);
    verdict_q.push_back(typed ? typed_verdict : predicted);
  endtask

  // all verdicts in, then time for a trailing join walk or clear
  task automatic settle_block();
    @(negedge clk_i);
    edge_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle_block();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_NODE_COUNT) cfg_nodes = val;
    else cfg_tie = val[0];
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      result_if.ready <= 1'b0;
      stall_left--;
    end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
      result_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (result_if.valid && result_if.ready) begin
      got = result_if.data;
      if (verdict_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected transfer: acc=%0d a=%0d b=%0d w=%08h done=%0d",
                   got.accepted, got.edge_a, got.edge_b, got.edge_weight, got.tree_done);
      end else begin
        want = verdict_q.pop_front();
        if (got.accepted !== want.accepted || got.edge_a !== want.edge_a ||
            got.edge_b !== want.edge_b || got.edge_weight !== want.edge_weight ||
            got.tree_done !== want.tree_done) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch got %0d/%0d/%0d/%08h/%0d exp %0d/%0d/%0d/%08h/%0d",
                     got.accepted, got.edge_a, got.edge_b, got.edge_weight, got.tree_done,
                     want.accepted, want.edge_a, want.edge_b, want.edge_weight, want.tree_done);
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    plan_row_t           directed_plan [23];
    result_t             typed_verdict;
    logic [CNT_W-1:0]    nodes;
    logic                tie;
    edge_t               e;
    logic [NODE_W-1:0]   swap_tmp;
    logic [WEIGHT_W-1:0] w;
    int                  sent;
    int                  graph_len;
    int                  eff;
    int                  tree_node;
    int                  roll;
    int                  pick;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_NODE_COUNT;
    cfg_wdata_i     = '0;
    edge_if.valid   = 1'b0;
    edge_if.data    = '0;
    clear_labels();
    group_wt   = '0;
    join_count = 0;
    cfg_nodes  = NODE_COUNT_RST;
    cfg_tie    = 1'b0;
    w          = '0;

    directed_plan = '{
      edge_row(ROW_CHECKED, 1'b1, 6'd0,  6'd1,  32'd1,          1'b1, 1'b0),
      edge_row(ROW_CHECKED, 1'b0, 6'd0,  6'd1,  32'd2,          1'b0, 1'b0),
      edge_row(ROW_CHECKED, 1'b0, 6'd63, 6'd62, 32'hFFFF_FFFF,  1'b1, 1'b0),
      edge_row(ROW_CHECKED, 1'b0, 6'd5,  6'd5,  32'hFFFF_FFFF,  1'b0, 1'b0),
      edge_row(ROW_EDGE,    1'b0, 6'd1,  6'd63, 32'hFFFF_FFFF,  1'b0, 1'b0),
      edge_row(ROW_CHECKED, 1'b1, 6'd0,  6'd0,  32'd0,          1'b0, 1'b0),
      reg_row(CFG_NODE_COUNT, 7'd1),
      edge_row(ROW_CHECKED, 1'b1, 6'd0,  6'd1,  32'd5,          1'b1, 1'b1),
      edge_row(ROW_CHECKED, 1'b0, 6'd2,  6'd3,  32'd6,          1'b0, 1'b1),
      edge_row(ROW_CHECKED, 1'b1, 6'd1,  6'd2,  32'd7,          1'b0, 1'b0),
      edge_row(ROW_CHECKED, 1'b0, 6'd1,  6'd0,  32'd7,          1'b1, 1'b1),
      reg_row(CFG_NODE_COUNT, 7'd127),
      reg_row(CFG_TIE_MODE, 7'd1),
      edge_row(ROW_CHECKED, 1'b1, 6'd0,  6'd1,  32'd10,         1'b1, 1'b0),
      edge_row(ROW_CHECKED, 1'b0, 6'd1,  6'd0,  32'd10,         1'b1, 1'b0),
      edge_row(ROW_EDGE,    1'b0, 6'd0,  6'd2,  32'd10,         1'b0, 1'b0),
      edge_row(ROW_EDGE,    1'b0, 6'd1,  6'd2,  32'd11,         1'b0, 1'b0),
      edge_row(ROW_EDGE,    1'b0, 6'd63, 6'd0,  32'd11,         1'b0, 1'b0),
      edge_row(ROW_EDGE,    1'b0, 6'd40, 6'd21, 32'd11,         1'b0, 1'b0),
      reg_row(CFG_TIE_MODE, 7'd0),
      edge_row(ROW_EDGE,    1'b0, 6'd63, 6'd1,  32'd12,         1'b0, 1'b0),
      reg_row(CFG_NODE_COUNT, 7'd64),
      edge_row(ROW_EDGE,    1'b0, 6'd42, 6'd21, 32'd12,         1'b0, 1'b0)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      typed_verdict = '{accepted: directed_plan[i].acc, edge_a: directed_plan[i].e.node_a,
                        edge_b: directed_plan[i].e.node_b,
                        edge_weight: directed_plan[i].e.weight,
                        tree_done: directed_plan[i].done};
      case (directed_plan[i].kind)
        ROW_REG: begin
          write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
        end
        ROW_CHECKED: begin
          send_edge(directed_plan[i].e, 1'b1, typed_verdict);
        end
        default: begin
          send_edge(directed_plan[i].e, 1'b0, typed_verdict);
        end
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          nodes = 7'd2;
          tie   = 1'b0;
        end
        1: begin
          nodes = 7'd64;
          tie   = 1'b1;
        end
        2: begin
          nodes = 7'd64;
          tie   = 1'b0;
        end
        3: begin
          nodes = 7'd2;
          tie   = 1'b1;
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6) nodes = CNT_W'($urandom_range(2, 16));
          else if (pick < 7) nodes = 7'd64;
          else if (pick < 9) nodes = CNT_W'($urandom_range(17, 63));
          else nodes = CNT_W'($urandom_range(0, 1) ? $urandom_range(0, 1) :
                                                     $urandom_range(65, 127));
          tie = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(CFG_NODE_COUNT, nodes);
      write_reg(CFG_TIE_MODE, {6'd0, tie});
      calm_tail = (phase == PHASES - 1);
      eff = (nodes < 2) ? 2 : ((nodes > NODE_CNT) ? NODE_CNT : nodes);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        graph_len = $urandom_range(1, 3 * eff);
        tree_node = 1;
        for (int k = 0; k < graph_len && sent < PHASE_ITEMS; k++) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) begin
            // grows a spanning tree one node at a time
            e.node_a  = NODE_W'(tree_node);
            e.node_b  = NODE_W'($urandom_range(0, tree_node - 1));
            tree_node = (tree_node >= eff - 1) ? 1 : tree_node + 1;
          end else if (roll < 85) begin
            e.node_a = NODE_W'($urandom_range(0, eff - 1));
            e.node_b = NODE_W'($urandom_range(0, eff - 1));
          end else if (roll < 93) begin
            e.node_a = NODE_W'($urandom_range(0, 63));
            e.node_b = NODE_W'($urandom_range(0, 63));
          end else begin
            e.node_a = NODE_W'($urandom_range(0, 63));
            e.node_b = e.node_a;
          end
          if ($urandom_range(0, 1)) begin
            swap_tmp = e.node_a;
            e.node_a = e.node_b;
            e.node_b = swap_tmp;
          end
          e.first_edge = (k == 0) || ($urandom_range(0, 49) == 0);
          if (k == 0 || $urandom_range(0, 29) == 0) w = $urandom;
          else if ($urandom_range(0, 1)) w = w + WEIGHT_W'($urandom_range(1, 4));
          e.weight = w;
          send_edge(e, 1'b0, '0);
          sent++;
        end
      end
    end

    settle_block();
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### kruskal_edge_selector_top.f
design/kes_pkg.sv
design/kes_edge_if.sv
design/kes_result_if.sv
design/kes_ram.sv
design/kes_ctrl.sv
design/kruskal_edge_selector_top.sv
verif/testbench.sv
